>>> hw/rtl/bms_pkg.sv
package bms_pkg;

   // built size of the store
   localparam int DEPTH = 64;
   localparam int VAL_W = 32;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // fixed field widths at the ports
   localparam int ITEM_W  = 32;
   localparam int MODE_W  = 2;
   localparam int CAP_W   = 7;
   localparam int COUNT_W = 7;
   localparam int RSP_W   = 16;

   localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD      = 2'd0,
      MODE_REMOVE   = 2'd1,
      MODE_CONTAINS = 2'd2,
      MODE_CLEAR    = 2'd3
   } mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic             wr_en;
      logic             shift_en;
      logic [CNT_W-1:0] count;
      logic [VAL_W-1:0] value;
   } cell_bus_type;

endpackage

>>> hw/rtl/bms_cell.sv
module bms_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [bms_pkg::IDX_W-1:0]  idx,
   input  bms_pkg::cell_bus_type      bus,
   input  logic                       act_i,
   input  logic                       hit_i,
   input  logic [bms_pkg::VAL_W-1:0]  right_entry,
   output logic                       act_o,
   output logic                       hit_o,
   output logic [bms_pkg::VAL_W-1:0]  entry_o
);
   import bms_pkg::*;

   logic [VAL_W-1:0] entry_ff;
   logic [VAL_W-1:0] entry_in;
   logic             act_ff;
   logic             hit_ff;
   logic             occupied;
   logic             match;

   assign occupied = CNT_W'(idx) < bus.count;
   assign match    = occupied && (entry_ff == bus.value);

   // hit carries "a match at or left of this cell" along with the scan token
   assign act_o   = act_ff;
   assign hit_o   = act_ff & (hit_ff | match);
   assign entry_o = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (bus.wr_en && (CNT_W'(idx) == bus.count)) begin
         entry_in = bus.value;
      end else if (bus.shift_en && hit_o) begin
         // right neighbor has not been touched yet in this pass
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         act_ff <= act_i;
         hit_ff <= hit_i;
      end
   end

endmodule

>>> hw/rtl/bounded_multiset_store.sv
// channel | dir | beat contents
// req     | in  | tdata: item_value[31:0]; tuser: mode[1:0]
// rsp     | out | tdata: ok, count[6:0], is_empty, is_full, zero pad to 16 bits
// csr     | in  | data: capacity[6:0], always ready
//
// add and clear: result registered in the cycle after the request beat.
// remove and contains: a token walks the cell row one cell per cycle, and the
// result is registered once the token reaches the last cell of the row.
// one item in flight; a new request is taken once the result register is free
// or being drained in that cycle. synchronous reset empties the store.
module bounded_multiset_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [bms_pkg::ITEM_W-1:0]   req_tdata,  // item_value
   input  logic [bms_pkg::MODE_W-1:0]   req_tuser,  // mode
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [bms_pkg::RSP_W-1:0]    rsp_tdata,  // ok, count, is_empty, is_full, pad
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [bms_pkg::CAP_W-1:0]    csr_data    // capacity
);
   import bms_pkg::*;

   state_type state_ff, state_in;

   logic [CAP_W-1:0]   cap_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   eff_cap;
   mode_type           op_ff, op_in, req_mode;
   logic [VAL_W-1:0]   value_ff, value_in, req_value;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_full_ff, rsp_full_in;

   logic               accept;
   logic               start;
   logic               scan_done;
   logic               found;
   logic               load;
   logic               ok_c;
   logic [CNT_W-1:0]   new_count;
   logic               wr_en;

   cell_bus_type       bus;

   logic               act_w   [DEPTH];
   logic               hit_w   [DEPTH];
   logic [VAL_W-1:0]   entry_w [DEPTH];

   assign req_mode  = mode_type'(req_tuser);
   assign req_value = VAL_W'(req_tdata);
   assign csr_ready = 1'b1;

   // capacity of zero acts as one, above the built depth acts as the depth
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(DEPTH)) begin
         eff_cap = CNT_W'(DEPTH);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   assign scan_done = act_w[DEPTH-1];
   assign found     = hit_w[DEPTH-1];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && ((req_mode == MODE_REMOVE) || (req_mode == MODE_CONTAINS))) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = !rsp_valid_ff || rsp_tready;
         ST_SCAN: req_tready = 1'b0;
         default: req_tready = 1'b0;
      endcase
   end

   assign accept = req_tvalid && req_tready;
   assign start  = accept && ((req_mode == MODE_REMOVE) || (req_mode == MODE_CONTAINS));

   always_comb begin
      op_in    = op_ff;
      value_in = value_ff;
      if (accept) begin
         op_in    = req_mode;
         value_in = req_value;
      end
   end

   // result and count update
   always_comb begin
      load      = 1'b0;
      ok_c      = 1'b0;
      new_count = count_ff;
      wr_en     = 1'b0;
      if (accept) begin
         case (req_mode)
            MODE_ADD: begin
               load = 1'b1;
               if (count_ff < eff_cap) begin
                  ok_c      = 1'b1;
                  wr_en     = 1'b1;
                  new_count = count_ff + CNT_W'(1);
               end
            end
            MODE_CLEAR: begin
               load      = 1'b1;
               ok_c      = 1'b1;
               new_count = '0;
            end
            MODE_REMOVE, MODE_CONTAINS: begin
               load = 1'b0;
            end
            default: load = 1'b0;
         endcase
      end else if ((state_ff == ST_SCAN) && scan_done) begin
         load = 1'b1;
         ok_c = found;
         if (found && (op_ff == MODE_REMOVE)) begin
            new_count = count_ff - CNT_W'(1);
         end
      end
   end

   assign count_in     = new_count;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   assign rsp_ok_in    = load ? ok_c : rsp_ok_ff;
   assign rsp_count_in = load ? COUNT_W'(new_count) : rsp_count_ff;
   assign rsp_empty_in = load ? (new_count == '0) : rsp_empty_ff;
   assign rsp_full_in  = load ? (new_count >= eff_cap) : rsp_full_ff;

   assign bus.wr_en    = wr_en;
   assign bus.shift_en = (state_ff == ST_SCAN) && (op_ff == MODE_REMOVE);
   assign bus.count    = count_ff;
   assign bus.value    = wr_en ? req_value : value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      value_ff     <= value_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_full_ff, rsp_empty_ff, rsp_count_ff, rsp_ok_ff});

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic             act_src;
      logic             hit_src;
      logic [VAL_W-1:0] right_src;

      if (i == 0) begin : g_head
         assign act_src = start;
         assign hit_src = 1'b0;
      end else begin : g_body
         assign act_src = act_w[i-1];
         assign hit_src = hit_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_src = entry_w[i];
      end else begin : g_link
         assign right_src = entry_w[i+1];
      end

      bms_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .idx         (IDX_W'(i)),
         .bus         (bus),
         .act_i       (act_src),
         .hit_i       (hit_src),
         .right_entry (right_src),
         .act_o       (act_w[i]),
         .hit_o       (hit_w[i]),
         .entry_o     (entry_w[i])
      );
   end

endmodule

>>> sim/tb_bounded_multiset_store.sv
`timescale 1ns / 100ps

module tb_bounded_multiset_store;
   import bms_pkg::*;

   typedef struct {
      logic             ok;
      logic [COUNT_W-1:0] count;
      logic             is_empty;
      logic             is_full;
   } status_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ITEM_W-1:0]   req_tdata;   // item_value
   logic [MODE_W-1:0]   req_tuser;   // mode
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_W-1:0]    rsp_tdata;   // ok, count[6:0], is_empty, is_full, zero pad
   logic                csr_valid;
   logic                csr_ready;
   logic [CAP_W-1:0]    csr_data;    // capacity

   // shadow of the store, kept in step with every accepted beat
   logic [VAL_W-1:0]    held_values [DEPTH];
   int                  held_count;
   logic [CAP_W-1:0]    cap_setting;
   status_type          status_due [$];
   logic [ITEM_W-1:0]   value_pool [8];

   int                  error_count;
   bit                  sender_gaps;
   bit                  sink_stalls;
   int                  sink_hold_cycles;

   bounded_multiset_store u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(40_000_000);
      $display("tb_bounded_multiset_store: errors");
      $finish;
   end

   function automatic status_type apply_store_op(mode_type mode, logic [ITEM_W-1:0] value);
      status_type st;
      int      limit;
      int      pos;
      limit = (cap_setting == 0) ? 1 : ((cap_setting > DEPTH) ? DEPTH : int'(cap_setting));
      st.ok = 1'b0;
      pos = held_count;
      for (int i = held_count - 1; i >= 0; i--)
         if (held_values[i] == value) pos = i;
      case (mode)
         MODE_ADD: begin
            if (held_count < limit) begin
               held_values[held_count] = value;
               held_count++;
               st.ok = 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (pos < held_count) begin
               // close the gap left by the first match
               for (int j = pos + 1; j < held_count; j++)
                  held_values[j-1] = held_values[j];
               held_count--;
               st.ok = 1'b1;
            end
         end
         MODE_CONTAINS: st.ok = (pos < held_count);
         default: begin
            held_count = 0;
            st.ok = 1'b1;
         end
      endcase
      st.count    = held_count[COUNT_W-1:0];
      st.is_empty = (held_count == 0);
      st.is_full  = (held_count >= limit);
      return st;
   endfunction

   task automatic report_mismatch(string what, int want, int got);
      $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what, want, got);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin : check_rsp
      status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (status_due.size() == 0) begin
            report_mismatch("unexpected result beat", 0, 1);
         end else begin
            want = status_due.pop_front();
            if (rsp_tdata[0] !== want.ok)
               report_mismatch("ok", want.ok, rsp_tdata[0]);
            if (rsp_tdata[7:1] !== want.count)
               report_mismatch("count", want.count, rsp_tdata[7:1]);
            if (rsp_tdata[8] !== want.is_empty)
               report_mismatch("is_empty", want.is_empty, rsp_tdata[8]);
            if (rsp_tdata[9] !== want.is_full)
               report_mismatch("is_full", want.is_full, rsp_tdata[9]);
            if (rsp_tdata[RSP_W-1:10] !== '0)
               report_mismatch("pad", 0, rsp_tdata[RSP_W-1:10]);
         end
      end
   end

   // result sink: random stalls, occasional long ones, and a forced hold-off on request
   initial begin : sink
      int stall;
      int r;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            stall = sink_hold_cycles;
            sink_hold_cycles = 0;
            repeat (stall) @(negedge clock);
         end else if (!sink_stalls) begin
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 199);
            if (r < 2) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(20, 80)) @(negedge clock);
            end else begin
               rsp_tready <= (r % 4 != 0);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!sender_gaps || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(mode_type mode, logic [ITEM_W-1:0] value);
      int gap;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      status_due.push_back(apply_store_op(mode, value));
   endtask

   task automatic set_capacity(logic [CAP_W-1:0] cap);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      do @(posedge clock); while (!csr_ready);
      cap_setting = cap;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_basic_ops();
      sender_gaps = 1'b1;
      sink_stalls = 1'b1;
      send_item(MODE_CONTAINS, 32'h0000_0000);
      send_item(MODE_REMOVE,   32'h0000_0005);
      send_item(MODE_CLEAR,    32'h0000_0000);
      send_item(MODE_ADD,      32'h0000_0000);
      send_item(MODE_ADD,      32'hFFFF_FFFF);
      send_item(MODE_ADD,      32'h8000_0000);
      send_item(MODE_ADD,      32'hFFFF_FFFF);
      send_item(MODE_ADD,      32'h0000_0001);
      send_item(MODE_CONTAINS, 32'hFFFF_FFFF);
      send_item(MODE_CONTAINS, 32'h0000_0002);
      // duplicates: each remove takes out one copy only
      send_item(MODE_REMOVE,   32'hFFFF_FFFF);
      send_item(MODE_CONTAINS, 32'hFFFF_FFFF);
      send_item(MODE_REMOVE,   32'hFFFF_FFFF);
      send_item(MODE_CONTAINS, 32'hFFFF_FFFF);
      send_item(MODE_REMOVE,   32'h0000_0000);
      send_item(MODE_CONTAINS, 32'h0000_0001);
      send_item(MODE_CLEAR,    32'hDEAD_BEEF);
      send_item(MODE_CONTAINS, 32'h0000_0001);
      send_item(MODE_REMOVE,   32'h0000_0001);
      send_item(MODE_ADD,      32'h7FFF_FFFF);
   endtask

   task automatic test_capacity_limits();
      logic [ITEM_W-1:0] fill_vals [DEPTH];
      sender_gaps = 1'b1;
      sink_stalls = 1'b1;
      // zero acts as one
      set_capacity(7'd0);
      send_item(MODE_CLEAR,    32'h0);
      send_item(MODE_ADD,      32'h1234_5678);
      send_item(MODE_ADD,      32'h8765_4321);
      send_item(MODE_CONTAINS, 32'h8765_4321);
      send_item(MODE_CLEAR,    32'h0);
      // above the built depth acts as the depth
      set_capacity(7'd127);
      for (int i = 0; i < DEPTH; i++) begin
         fill_vals[i] = $urandom;
         send_item(MODE_ADD, fill_vals[i]);
      end
      send_item(MODE_ADD,      32'hA5A5_A5A5);
      send_item(MODE_CONTAINS, fill_vals[DEPTH-1]);
      // lowered under the count: entries stay, adds refused until it drops
      set_capacity(7'd3);
      send_item(MODE_ADD, 32'h5A5A_5A5A);
      for (int i = 0; i < DEPTH - 2; i++)
         send_item(MODE_REMOVE, fill_vals[i]);
      send_item(MODE_ADD,      32'h5A5A_5A5A);
      send_item(MODE_ADD,      32'h5A5A_5A5B);
      send_item(MODE_CONTAINS, fill_vals[DEPTH-1]);
      send_item(MODE_CLEAR,    32'h0);
      set_capacity(7'd64);
   endtask

   task automatic test_backpressure();
      sender_gaps = 1'b0;
      sink_stalls = 1'b0;
      sink_hold_cycles = 300;
      for (int i = 0; i < 30; i++)
         send_item((i % 3 == 2) ? MODE_CONTAINS : MODE_ADD, $urandom_range(0, 7));
   endtask

   task automatic test_random_traffic(logic [CAP_W-1:0] cap, int n_items, bit with_idle);
      int               r;
      mode_type         mode;
      logic [ITEM_W-1:0] value;
      set_capacity(cap);
      sender_gaps = with_idle;
      sink_stalls = with_idle;
      for (int i = 0; i < 8; i++)
         value_pool[i] = $urandom;
      value_pool[0] = '0;
      value_pool[1] = '1;
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         if (r < 40)      mode = MODE_ADD;
         else if (r < 65) mode = MODE_REMOVE;
         else if (r < 95) mode = MODE_CONTAINS;
         else             mode = MODE_CLEAR;
         // mostly pool values so removes and lookups hit
         value = ($urandom_range(0, 99) < 80) ? value_pool[$urandom_range(0, 7)] : $urandom;
         send_item(mode, value);
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = MODE_ADD;
      csr_valid        = 1'b0;
      csr_data         = '0;
      cap_setting      = CAP_RESET;
      held_count       = 0;
      error_count      = 0;
      sender_gaps      = 1'b0;
      sink_stalls      = 1'b0;
      sink_hold_cycles = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_capacity_limits();
      test_backpressure();
      test_random_traffic(7'd64, 250, 1'b1);
      test_random_traffic(7'd1, 120, 1'b1);
      test_random_traffic(7'd0, 80, 1'b1);
      test_random_traffic(7'd127, 200, 1'b0);
      test_random_traffic(7'd5, 150, 1'b1);
      test_random_traffic(CAP_W'($urandom_range(2, 63)), 200, 1'b1);
      test_random_traffic(7'd64, 200, 1'b1);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (status_due.size() != 0) @(posedge clock);
      repeat (DEPTH + 10) @(posedge clock);
      if (error_count == 0)
         $display("tb_bounded_multiset_store: clean");
      else
         $display("tb_bounded_multiset_store: errors");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/bms_pkg.sv
hw/rtl/bms_cell.sv
hw/rtl/bounded_multiset_store.sv
sim/tb_bounded_multiset_store.sv
